[rtl/knfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knfd_pkg: shared types and constants
// Item layouts, configuration layout, command format and sequencer states
// for the kth nearest feature distance block.
// ----------------------------------------------------------------------------
package knfd_pkg;

  localparam int COORD_BITS     = 16;
  localparam int POINTS_DEFAULT = 256;
  localparam int IDX_W          = 8;
  localparam int CNT_W          = 9;
  localparam int RANK_W         = 2;
  localparam int DIST_W         = 33;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [RANK_W-1:0] RANK_THIRD = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKE_ROOT   = 2'd2;

  typedef struct packed {
    logic                         opcode;
    logic [IDX_W-1:0]             point_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              found;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  num_points;
    logic [RANK_W-1:0] rank_select;
    logic              take_root;
  } cfg_t;

  // decoded item as queued between front and back
  typedef struct packed {
    logic                         is_query;
    logic                         in_range;
    logic [IDX_W-1:0]             point_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_SELECT,
    S_ROOT,
    S_EMIT
  } back_state_t;

endpackage

[rtl/kth_nearest_feature_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_nearest_feature_distance: cellular (F1/F2/F3) distance engine
// Holds a table of 2-D feature points and answers kth-nearest queries.
//
// Input channel (in_push / in_full): a load transfer writes one point into
// the table, a query transfer gives a point to measure against the table.
// Items go through a two-entry queue and execute in order.
// Result channel (out_empty / out_pop): one result per query, none per load.
// Config channel (cfg_valid / cfg_ready, always ready): num_points,
// rank_select, take_root; write only while the block is idle.
// A query walks n = min(num_points, POINTS) table entries: the table RAM
// read port delivers one point per cycle into the distance pipeline (abs
// diff, squares, saturated sum). With take_root set and a point found,
// the bit-serial square root runs before the result is emitted.
// A finished result waits in the output register; while it is not popped the
// next query stalls at emit, and the input queue fills and raises in_full.
// Reset clears the configuration, the control and valid registers and the
// queue counts; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module kth_nearest_feature_distance #(
  parameter int POINTS = knfd_pkg::POINTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  knfd_pkg::in_item_t              in_item,
  output logic                            out_empty,
  input  logic                            out_pop,
  output knfd_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [knfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  knfd_pkg::cfg_t cfg_r;
  logic           cmd_valid;
  logic           cmd_pop;
  knfd_pkg::cmd_t cmd;
  logic           out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        knfd_pkg::CFG_NUM_POINTS:  cfg_r.num_points  <= cfg_data[knfd_pkg::CNT_W-1:0];
        knfd_pkg::CFG_RANK_SELECT: cfg_r.rank_select <= cfg_data[knfd_pkg::RANK_W-1:0];
        knfd_pkg::CFG_TAKE_ROOT:   cfg_r.take_root   <= cfg_data[0];
        default:                   cfg_r             <= cfg_r;
      endcase
    end
  end

  knfd_front #(
    .POINTS (POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  knfd_back #(
    .POINTS (POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign out_empty = !out_valid;

endmodule

[rtl/knfd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knfd_ram: simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module knfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/knfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knfd_front: input side
// Takes input transfers, decodes opcode and slot range, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module knfd_front #(
  parameter int POINTS = knfd_pkg::POINTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  knfd_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output knfd_pkg::cmd_t     cmd
);

  knfd_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push_ok;
  logic           pop_ok;
  knfd_pkg::cmd_t dec;

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    dec.is_query    = (in_item.opcode == knfd_pkg::OP_QUERY);
    dec.in_range    = (int'(in_item.point_index) < POINTS);
    dec.point_index = in_item.point_index;
    dec.coord_x     = in_item.coord_x;
    dec.coord_y     = in_item.coord_y;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push_ok, pop_ok})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/knfd_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knfd_isqrt: iterative integer square root
// Floor root, one result bit per cycle; done pulses after the last step.
// ----------------------------------------------------------------------------
module knfd_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [knfd_pkg::DIST_W-1:0] value,
  output logic                        done,
  output logic [knfd_pkg::DIST_W-1:0] root
);

  // two spare bits so the first trial bit sits at an even position above value
  localparam int W = knfd_pkg::DIST_W + 2;

  logic [W-1:0] v_r;
  logic [W-1:0] res_r;
  logic [W-1:0] bit_r;
  logic         busy_r;
  logic         done_r;
  logic [W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= W'(value);
      res_r <= '0;
      bit_r <= {1'b1, {(W-1){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = res_r[knfd_pkg::DIST_W-1:0];

endmodule

[rtl/knfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knfd_back: execution side
// Writes loads into the point table; for a query walks the table through a
// distance pipeline, keeps the three smallest distances and emits a result.
// ----------------------------------------------------------------------------
module knfd_back #(
  parameter int POINTS = knfd_pkg::POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  knfd_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  knfd_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_pop,
  output knfd_pkg::out_item_t out_item
);

  localparam int AW    = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CB    = knfd_pkg::COORD_BITS;
  localparam int AD_W  = CB + 1;
  localparam int SQ_W  = 2 * AD_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int DW    = knfd_pkg::DIST_W;
  localparam int NW    = knfd_pkg::CNT_W;

  knfd_pkg::back_state_t state_r, state_nxt;

  logic signed [CB-1:0] qx_r, qy_r;
  logic [NW-1:0]        n_r, n_c;
  logic [NW-1:0]        issue_r;
  logic                 start_query;
  logic                 rd_en;
  logic                 ram_we;
  logic [2*CB-1:0]      rdata;
  logic                 rd_valid_r;

  logic signed [CB-1:0]   px, py;
  logic signed [AD_W-1:0] dfx, dfy;
  logic [AD_W-1:0]        adx_r, ady_r;
  logic                   v1_r;
  logic [SQ_W-1:0]        sqx_r, sqy_r;
  logic                   v2_r;
  logic [SUM_W-1:0]       sum_c;
  logic [DW-1:0]          d_r;
  logic                   v3_r;

  logic [DW-1:0]  best0_r, best1_r, best2_r;
  logic [1:0]     held_r;
  logic [knfd_pkg::RANK_W-1:0] rank;
  logic           found_c;
  logic [DW-1:0]  pick_c;

  logic           sel_load;
  logic           root_load;
  logic           emit;
  logic           sq_start;
  logic           sq_done;
  logic [DW-1:0]  sq_root;
  logic [DW-1:0]  result_r;
  logic           found_r;

  logic                out_valid_r;
  knfd_pkg::out_item_t out_item_r;

  // clamp the count to the table depth
  always_comb begin
    if (int'(cfg.num_points) > POINTS) begin
      n_c = NW'(POINTS);
    end else begin
      n_c = cfg.num_points;
    end
  end

  knfd_ram #(
    .WIDTH (2 * CB),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(cmd.point_index)),
    .wdata ({cmd.coord_x, cmd.coord_y}),
    .re    (rd_en),
    .raddr (AW'(issue_r)),
    .rdata (rdata)
  );

  // distance pipeline: abs diff, squares, saturated sum
  assign px    = rdata[2*CB-1:CB];
  assign py    = rdata[CB-1:0];
  assign dfx   = AD_W'(qx_r) - AD_W'(px);
  assign dfy   = AD_W'(qy_r) - AD_W'(py);
  assign sum_c = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  always_ff @(posedge clk) begin
    adx_r <= dfx[AD_W-1] ? AD_W'(-dfx) : AD_W'(dfx);
    ady_r <= dfy[AD_W-1] ? AD_W'(-dfy) : AD_W'(dfy);
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    if (sum_c > SUM_W'(knfd_pkg::DIST_MAX)) begin
      d_r <= knfd_pkg::DIST_MAX;
    end else begin
      d_r <= sum_c[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
      v1_r       <= rd_valid_r;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
    end
  end

  // sorted insertion into the three best slots; ties take their own rank
  always_ff @(posedge clk) begin
    if (v3_r) begin
      if (held_r == 2'd0 || d_r < best0_r) begin
        best2_r <= best1_r;
        best1_r <= best0_r;
        best0_r <= d_r;
      end else if (held_r < 2'd2 || d_r < best1_r) begin
        best2_r <= best1_r;
        best1_r <= d_r;
      end else if (held_r < 2'd3 || d_r < best2_r) begin
        best2_r <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
    end else if (start_query) begin
      held_r <= 2'd0;
    end else if (v3_r && held_r != 2'd3) begin
      held_r <= held_r + 2'd1;
    end
  end

  assign rank    = (cfg.rank_select > knfd_pkg::RANK_THIRD) ? knfd_pkg::RANK_THIRD
                                                            : cfg.rank_select;
  assign found_c = (held_r > rank);

  always_comb begin
    case (rank)
      2'd0:    pick_c = best0_r;
      2'd1:    pick_c = best1_r;
      default: pick_c = best2_r;
    endcase
  end

  knfd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (pick_c),
    .done  (sq_done),
    .root  (sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knfd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_pop     = 1'b0;
    start_query = 1'b0;
    ram_we      = 1'b0;
    rd_en       = 1'b0;
    sel_load    = 1'b0;
    sq_start    = 1'b0;
    root_load   = 1'b0;
    emit        = 1'b0;
    case (state_r)
      knfd_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_query) begin
            start_query = 1'b1;
            state_nxt   = (n_c == '0) ? knfd_pkg::S_SELECT : knfd_pkg::S_WALK;
          end else begin
            ram_we = cmd.in_range;
          end
        end
      end
      knfd_pkg::S_WALK: begin
        rd_en = 1'b1;
        if (issue_r == n_r - NW'(1)) begin
          state_nxt = knfd_pkg::S_DRAIN;
        end
      end
      knfd_pkg::S_DRAIN: begin
        if (!(rd_valid_r || v1_r || v2_r || v3_r)) begin
          state_nxt = knfd_pkg::S_SELECT;
        end
      end
      knfd_pkg::S_SELECT: begin
        sel_load = 1'b1;
        if (found_c && cfg.take_root) begin
          sq_start  = 1'b1;
          state_nxt = knfd_pkg::S_ROOT;
        end else begin
          state_nxt = knfd_pkg::S_EMIT;
        end
      end
      knfd_pkg::S_ROOT: begin
        if (sq_done) begin
          root_load = 1'b1;
          state_nxt = knfd_pkg::S_EMIT;
        end
      end
      knfd_pkg::S_EMIT: begin
        if (!out_valid_r) begin
          emit      = 1'b1;
          state_nxt = knfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = knfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      qx_r <= cmd.coord_x;
      qy_r <= cmd.coord_y;
      n_r  <= n_c;
    end
    if (sel_load) begin
      result_r <= found_c ? pick_c : '0;
      found_r  <= found_c;
    end else if (root_load) begin
      result_r <= sq_root;
    end
    if (emit) begin
      out_item_r.distance <= result_r;
      out_item_r.found    <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start_query) begin
        issue_r <= '0;
      end else if (rd_en) begin
        issue_r <= issue_r + NW'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
